// ===== rtl/izba_pkg.sv =====
// Shared types, codes and sizes for the inode and zone bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package izba_pkg;

   // Fixed field widths and default sizes.
   localparam int WORD_BITS          = 64;
   localparam int BIT_SEL_W          = 6;
   localparam int NUM_W              = 16;
   localparam int BLKCNT_W           = 4;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 16;
   localparam int BLOCK_BITS_DEFAULT = 8192;
   localparam int MAP_BLOCKS_DEFAULT = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_INODE_COUNT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_COUNT       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_DATA_ZONE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INODE_MAP_BLOCKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_MAP_BLOCKS  = 3'd4;

   // Request operations.
   typedef enum logic [1:0] {
      OP_ALLOC_INODE = 2'd0,
      OP_FREE_INODE  = 2'd1,
      OP_ALLOC_ZONE  = 2'd2,
      OP_FREE_ZONE   = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_RANGE  = 2'd2,
      ST_DOUBLE = 2'd3
   } status_type;

   // Payload of one request transfer.
   typedef struct packed {
      op_type           op;
      logic [NUM_W-1:0] number;
   } req_type;

   // Payload of one result transfer.
   typedef struct packed {
      logic [NUM_W-1:0] granted;
      status_type       status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load_req;
      logic check;
      logic scan;
      logic free_eval;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic early_done;
      logic is_alloc;
      logic scan_found;
      logic scan_at_top;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/izba_datapath.sv =====
// Datapath: configuration registers, the two bitmap memories, word scan and result registers.
`timescale 1ns / 1ps
`default_nettype none

module izba_datapath import izba_pkg::*; #(
   parameter int BLOCK_BITS = BLOCK_BITS_DEFAULT,
   parameter int MAP_BLOCKS = MAP_BLOCKS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire req_type                req_data,
   output rsp_type                     rsp_data,
   input  wire cmd_type                cmd,
   output sts_type                     sts
);

   localparam int TOTAL_BITS = MAP_BLOCKS * BLOCK_BITS;
   localparam int MAP_WORDS  = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SW         = $clog2(TOTAL_BITS + 1);
   localparam int CW         = (SW > NUM_W + 1) ? SW : NUM_W + 1;
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

   // Configuration registers.
   logic [NUM_W-1:0]    inode_count_ff;
   logic [NUM_W-1:0]    zone_count_ff;
   logic [NUM_W-1:0]    first_zone_ff;
   logic [BLKCNT_W-1:0] inode_blocks_ff;
   logic [BLKCNT_W-1:0] zone_blocks_ff;

   // Request, pointers and results.
   op_type              op_ff;
   logic [NUM_W-1:0]    number_ff;
   logic [AW-1:0]       eval_addr_ff;
   logic [AW-1:0]       clr_addr_ff;
   rsp_type             result_ff;
   rsp_type             result_in;
   rsp_type             rsp_data_ff;

   // Bitmap memories and their read registers.
   logic [WORD_BITS-1:0] inode_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] zone_mem  [MAP_WORDS];
   logic [WORD_BITS-1:0] inode_rd_ff;
   logic [WORD_BITS-1:0] zone_rd_ff;

   // Decode and limit signals.
   logic                 zone_sel;
   logic                 is_alloc;
   logic [BLKCNT_W-1:0]  blocks;
   logic [BLKCNT_W-1:0]  blocks_sat;
   logic [CW-1:0]        span_c;
   logic [CW-1:0]        span_m1;
   logic [NUM_W-1:0]     limit;
   logic [CW-1:0]        top_c;
   logic [AW-1:0]        top_word;
   logic [BIT_SEL_W-1:0] top_bit;
   logic [CW-1:0]        free_idx_c;
   logic [BIT_SEL_W-1:0] free_bit;
   logic                 free_range;
   logic                 alloc_full_now;
   logic                 early_done;
   status_type           early_status;

   // Read, scan and write signals.
   logic                 rd_en;
   logic [AW-1:0]        first_addr;
   logic [AW-1:0]        rd_addr;
   logic                 at_top;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] cand;
   logic                 found;
   logic [BIT_SEL_W-1:0] found_bit;
   logic [AW+BIT_SEL_W-1:0] alloc_idx;
   logic [NUM_W-1:0]     granted;
   logic [WORD_BITS-1:0] set_word;
   logic [WORD_BITS-1:0] clr_word;
   logic                 free_bit_set;
   logic                 mem_wr;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 inode_we;
   logic                 zone_we;

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         inode_count_ff  <= '0;
         zone_count_ff   <= '0;
         first_zone_ff   <= '0;
         inode_blocks_ff <= '0;
         zone_blocks_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INODE_COUNT:      inode_count_ff  <= csr_wdata;
            CSR_ZONE_COUNT:       zone_count_ff   <= csr_wdata;
            CSR_FIRST_DATA_ZONE:  first_zone_ff   <= csr_wdata;
            CSR_INODE_MAP_BLOCKS: inode_blocks_ff <= csr_wdata[BLKCNT_W-1:0];
            CSR_ZONE_MAP_BLOCKS:  zone_blocks_ff  <= csr_wdata[BLKCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the request on its transfer.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_data.op;
         number_ff <= req_data.number;
      end
   end

   // Which map is addressed and how far its search may go.
   always_comb begin
      zone_sel   = (op_ff == OP_ALLOC_ZONE) || (op_ff == OP_FREE_ZONE);
      is_alloc   = (op_ff == OP_ALLOC_INODE) || (op_ff == OP_ALLOC_ZONE);
      blocks     = zone_sel ? zone_blocks_ff : inode_blocks_ff;
      blocks_sat = (32'(blocks) > 32'(MAP_BLOCKS)) ? BLKCNT_W'(MAP_BLOCKS) : blocks;
      span_c     = CW'(blocks_sat) * CW'(BLOCK_BITS);
      span_m1    = span_c - CW'(1);
      limit      = zone_sel ? (zone_count_ff - first_zone_ff) : inode_count_ff;
      top_c      = (CW'(limit) > span_m1) ? span_m1 : CW'(limit);
      top_word   = AW'(top_c >> BIT_SEL_W);
      top_bit    = top_c[BIT_SEL_W-1:0];
   end

   // Range checks for a free and the early answers.
   always_comb begin
      free_idx_c = zone_sel ? (CW'(number_ff) - CW'(first_zone_ff) + CW'(1))
                            : CW'(number_ff);
      free_bit   = free_idx_c[BIT_SEL_W-1:0];
      if (zone_sel) begin
         free_range = (number_ff < first_zone_ff) || (number_ff >= zone_count_ff) ||
                      (free_idx_c >= span_c);
      end else begin
         free_range = (number_ff == '0) || (number_ff > inode_count_ff) ||
                      (free_idx_c >= span_c);
      end
      alloc_full_now = (blocks_sat == '0) || (top_c == '0) ||
                       (zone_sel && (first_zone_ff > zone_count_ff));
      early_done     = is_alloc ? alloc_full_now : free_range;
      early_status   = is_alloc ? ST_FULL : ST_RANGE;
   end

   // Read address: first word on the check step, then one word further per scan step, up to the top word.
   always_comb begin
      at_top     = (eval_addr_ff == top_word);
      first_addr = is_alloc ? '0 : AW'(free_idx_c >> BIT_SEL_W);
      rd_en      = (cmd.check && !early_done) || cmd.scan;
      if (cmd.check) begin
         rd_addr = first_addr;
      end else if (at_top) begin
         rd_addr = eval_addr_ff;
      end else begin
         rd_addr = eval_addr_ff + AW'(1);
      end
   end

   // Address of the word that sits in the read register.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         eval_addr_ff <= rd_addr;
      end
   end

   // Clearing pass counter after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // Lowest clear bit of the current word that lies between one and the top index (the limit, capped to the map span).
   always_comb begin
      rd_word   = zone_sel ? zone_rd_ff : inode_rd_ff;
      found_bit = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         cand[j] = !rd_word[j] &&
                   ((eval_addr_ff != top_word) || (BIT_SEL_W'(j) <= top_bit)) &&
                   ((eval_addr_ff != '0) || (j != 0));
      end
      found = |cand;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (cand[j]) begin
            found_bit = BIT_SEL_W'(j);
         end
      end
      alloc_idx = {eval_addr_ff, found_bit};
      if (zone_sel) begin
         granted = NUM_W'(32'(first_zone_ff) + 32'(alloc_idx) - 32'd1);
      end else begin
         granted = NUM_W'(alloc_idx);
      end
   end

   // Updated word and write port selection.
   always_comb begin
      set_word     = rd_word | (WORD_BITS'(1) << found_bit);
      clr_word     = rd_word & ~(WORD_BITS'(1) << free_bit);
      free_bit_set = rd_word[free_bit];
      mem_wr       = (cmd.scan && found) || (cmd.free_eval && free_bit_set);
      wr_addr      = cmd.clear ? clr_addr_ff : eval_addr_ff;
      if (cmd.clear) begin
         wr_data = '0;
      end else if (cmd.scan) begin
         wr_data = set_word;
      end else begin
         wr_data = clr_word;
      end
      inode_we = cmd.clear || (mem_wr && !zone_sel);
      zone_we  = cmd.clear || (mem_wr && zone_sel);
   end

   // Inode bitmap memory.
   always_ff @(posedge clock) begin
      if (inode_we) begin
         inode_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         inode_rd_ff <= inode_mem[rd_addr];
      end
   end

   // Zone bitmap memory.
   always_ff @(posedge clock) begin
      if (zone_we) begin
         zone_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         zone_rd_ff <= zone_mem[rd_addr];
      end
   end

   // Result of the request, settled on the step that decides it.
   always_comb begin
      result_in = result_ff;
      if (cmd.check && early_done) begin
         result_in.granted = '0;
         result_in.status  = early_status;
      end else if (cmd.scan) begin
         if (found) begin
            result_in.granted = granted;
            result_in.status  = ST_OK;
         end else if (at_top) begin
            result_in.granted = '0;
            result_in.status  = ST_FULL;
         end
      end else if (cmd.free_eval) begin
         result_in.granted = '0;
         result_in.status  = free_bit_set ? ST_OK : ST_DOUBLE;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      if (cmd.rsp_load) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

   // Status back to the controller.
   always_comb begin
      sts.clear_last  = (clr_addr_ff == LAST_WORD);
      sts.early_done  = early_done;
      sts.is_alloc    = is_alloc;
      sts.scan_found  = found;
      sts.scan_at_top = at_top;
   end

endmodule

`default_nettype wire

// ===== rtl/izba_ctrl.sv =====
// Controller: state machine that sequences clearing, checks, word scans and result transfers.
`timescale 1ns / 1ps
`default_nettype none

module izba_ctrl import izba_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FREE,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.early_done) begin
               state_in = S_DONE;
            end else if (sts.is_alloc) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_FREE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_found || sts.scan_at_top) begin
               state_in = S_DONE;
            end
         end
         S_FREE: begin
            cmd.free_eval = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid holds until its transfer completes.
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/inode_zone_bitmap_allocator.sv =====
// Top level of the first-fit inode and zone bitmap allocator.
//
// Requests arrive on the req_ channel (valid/stall); each carries an operation
// (allocate or free, inode or zone) and a number used by frees. Each request
// gives exactly one result on the rsp_ channel: the granted number and a status.
// Configuration registers are written through the csr_ port; the user is to
// write them only while idle, which the block does not enforce. One request
// is handled at a time. An allocation scans one 64-bit bitmap word per cycle,
// up to top/64 + 1 words (at most 1024 with the default sizes). A new request
// is taken while the previous result still waits for transfer. After reset
// both bitmaps are swept clear, one word per cycle, all MAP_WORDS words
// (1024 with the default sizes); no request is taken during the sweep, but
// configuration writes are. When the receiver stalls, the result holds in the
// output register and the next result waits until that transfer completes.
`timescale 1ns / 1ps
`default_nettype none

module inode_zone_bitmap_allocator import izba_pkg::*; #(
   parameter int BLOCK_BITS = BLOCK_BITS_DEFAULT,
   parameter int MAP_BLOCKS = MAP_BLOCKS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequencing.
   izba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Bitmaps, search and results.
   izba_datapath #(
      .BLOCK_BITS (BLOCK_BITS),
      .MAP_BLOCKS (MAP_BLOCKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire
